/* src/ffpa_pkg.sv */
// Shared constants for the first-fit page allocator: page geometry,
// operation codes, status codes and configuration register indexes.
// No dependencies.
`default_nettype none

package ffpa_pkg;

  localparam int PAGE_BYTES = 4096;
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int BYTES_W    = 32;
  localparam int NEED_W     = BYTES_W + 1 - PAGE_SHIFT;
  localparam int ADDR_W     = 64;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NO_FIT   = 2'd1;
  localparam logic [1:0] STATUS_BAD_ADDR = 2'd2;

  localparam logic CFG_VIRT_BASE = 1'b0;
  localparam logic CFG_PHYS_BASE = 1'b1;

endpackage

`default_nettype wire

/* src/first_fit_page_allocator_core.sv */
// First-fit page allocator core: block table memory, walk sequencer and
// result register. Depends on ffpa_pkg.
`default_nettype none

// After reset the core sweeps its block table, one page per cycle, with
// req_stall high; configuration writes are taken meanwhile. Requests are
// then handled one at a time. Every table read passes through a wait state
// for the synchronous read and an evaluate state, and every pointer step goes
// through a single shared adder. The merge walk of a free reads both sides of
// every block boundary. A zero size or a zero free address goes straight to
// the result state. The result register lets the core take the next request
// while a result still waits on rsp_stall.
module first_fit_page_allocator_core #(
  parameter int POOL_PAGES = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  output logic             req_stall,
  input  wire logic        op,
  input  wire logic [31:0] request_bytes,
  input  wire logic [63:0] release_address,
  output logic             rsp_valid,
  input  wire logic        rsp_stall,
  output logic [1:0]       status,
  output logic [63:0]      granted_virtual,
  output logic [63:0]      granted_physical,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [63:0] cfg_data
);

  localparam int PW     = $clog2(POOL_PAGES);
  localparam int CNT_W  = $clog2(POOL_PAGES + 1);
  localparam int PTR_W  = CNT_W + 1;
  localparam int WORD_W = CNT_W + 2;
  localparam int CMP_W  = ((ffpa_pkg::NEED_W > CNT_W) ? ffpa_pkg::NEED_W : CNT_W) + 1;
  localparam int HI_W   = ffpa_pkg::ADDR_W - ffpa_pkg::PAGE_SHIFT;

  localparam logic [3:0] ST_CLEAR  = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_A_WAIT = 4'd2;
  localparam logic [3:0] ST_A_EVAL = 4'd3;
  localparam logic [3:0] ST_A_SPLIT = 4'd4;
  localparam logic [3:0] ST_A_TAKE = 4'd5;
  localparam logic [3:0] ST_F_CHECK = 4'd6;
  localparam logic [3:0] ST_F_WAIT = 4'd7;
  localparam logic [3:0] ST_F_EVAL = 4'd8;
  localparam logic [3:0] ST_C_WAITP = 4'd9;
  localparam logic [3:0] ST_C_EVALP = 4'd10;
  localparam logic [3:0] ST_C_WAITQ = 4'd11;
  localparam logic [3:0] ST_C_EVALQ = 4'd12;
  localparam logic [3:0] ST_C_CLRQ = 4'd13;
  localparam logic [3:0] ST_RESULT = 4'd14;

  logic [WORD_W-1:0] mem [POOL_PAGES];
  logic [WORD_W-1:0] rd_word;
  logic [PW-1:0]     rd_addr;
  logic              wr_en;
  logic [PW-1:0]     wr_addr;
  logic [WORD_W-1:0] wr_word;

  logic [3:0]                   state;
  logic [PW-1:0]                p;
  logic [ffpa_pkg::NEED_W-1:0]  need;
  logic [CNT_W-1:0]             sz;
  logic [CNT_W-1:0]             take_cnt;
  logic                         p_free;
  logic [63:0]                  addr;
  logic [1:0]                   res_status;
  logic                         res_grant;
  logic [63:0]                  virt_base;
  logic [63:0]                  phys_base;

  logic             rd_start;
  logic             rd_free;
  logic [CNT_W-1:0] rd_count;
  logic [PTR_W-1:0] nxt;
  logic             nxt_out;
  logic [CMP_W-1:0] size_c;
  logic [CMP_W-1:0] need_c;
  logic             fit;
  logic             split;
  logic [32:0]      bytes_up;
  logic [63:0]      off;
  logic             off_bad;
  logic [63:0]      page_off;
  logic             slot_free;

  assign rd_start = rd_word[WORD_W-1];
  assign rd_free  = rd_word[WORD_W-2];
  assign rd_count = rd_word[CNT_W-1:0];

  assign nxt     = PTR_W'(p) + PTR_W'(rd_count);
  assign nxt_out = nxt >= PTR_W'(POOL_PAGES);
  assign size_c  = CMP_W'(rd_count);
  assign need_c  = CMP_W'(need);
  assign fit     = rd_start && rd_free && (size_c >= need_c);
  assign split   = size_c > (need_c + CMP_W'(1));

  assign bytes_up = {1'b0, request_bytes} + 33'(ffpa_pkg::PAGE_BYTES - 1);
  assign off      = addr - virt_base;
  assign off_bad  = (off[ffpa_pkg::PAGE_SHIFT-1:0] != '0) ||
                    (off[63:ffpa_pkg::PAGE_SHIFT] >= HI_W'(POOL_PAGES));
  assign page_off = 64'(p) << ffpa_pkg::PAGE_SHIFT;

  assign slot_free = !rsp_valid || !rsp_stall;
  assign req_stall = (state != ST_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = p;
    wr_word = '0;
    case (state)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_word = (p == '0) ? {2'b11, CNT_W'(POOL_PAGES)} : '0;
      end
      ST_A_SPLIT: begin
        wr_en   = 1'b1;
        wr_addr = PW'(CMP_W'(p) + need_c);
        wr_word = {2'b11, CNT_W'(CMP_W'(sz) - need_c)};
      end
      ST_A_TAKE: begin
        wr_en   = 1'b1;
        wr_word = {2'b10, take_cnt};
      end
      ST_F_EVAL: begin
        wr_en   = rd_start;
        wr_word = {2'b11, rd_count};
      end
      ST_C_EVALQ: begin
        wr_en   = p_free && rd_free;
        wr_word = {2'b11, CNT_W'(sz + rd_count)};
      end
      ST_C_CLRQ: begin
        wr_en   = 1'b1;
        wr_addr = rd_addr;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_word;
    end
    rd_word <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      p         <= '0;
      rsp_valid <= 1'b0;
      virt_base <= '0;
      phys_base <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          ffpa_pkg::CFG_VIRT_BASE: virt_base <= cfg_data;
          ffpa_pkg::CFG_PHYS_BASE: phys_base <= cfg_data;
          default: virt_base <= virt_base;
        endcase
      end
      if (rsp_valid && !rsp_stall && (state != ST_RESULT)) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          if (p == PW'(POOL_PAGES - 1)) begin
            p     <= '0;
            state <= ST_IDLE;
          end else begin
            p <= p + PW'(1);
          end
        end
        ST_IDLE: begin
          if (req_valid) begin
            addr      <= release_address;
            need      <= bytes_up[32:ffpa_pkg::PAGE_SHIFT];
            p         <= '0;
            rd_addr   <= '0;
            res_grant <= 1'b0;
            if (op == ffpa_pkg::OP_ALLOC) begin
              if (request_bytes == '0) begin
                res_status <= ffpa_pkg::STATUS_NO_FIT;
                state      <= ST_RESULT;
              end else begin
                state <= ST_A_WAIT;
              end
            end else if (release_address == '0) begin
              res_status <= ffpa_pkg::STATUS_OK;
              state      <= ST_RESULT;
            end else begin
              state <= ST_F_CHECK;
            end
          end
        end
        ST_A_WAIT: begin
          state <= ST_A_EVAL;
        end
        ST_A_EVAL: begin
          sz <= rd_count;
          if (rd_count == '0) begin
            res_status <= ffpa_pkg::STATUS_NO_FIT;
            state      <= ST_RESULT;
          end else if (fit) begin
            take_cnt <= split ? CNT_W'(need) : rd_count;
            state    <= split ? ST_A_SPLIT : ST_A_TAKE;
          end else if (nxt_out) begin
            res_status <= ffpa_pkg::STATUS_NO_FIT;
            state      <= ST_RESULT;
          end else begin
            p       <= PW'(nxt);
            rd_addr <= PW'(nxt);
            state   <= ST_A_WAIT;
          end
        end
        ST_A_SPLIT: begin
          state <= ST_A_TAKE;
        end
        ST_A_TAKE: begin
          res_status <= ffpa_pkg::STATUS_OK;
          res_grant  <= 1'b1;
          state      <= ST_RESULT;
        end
        ST_F_CHECK: begin
          if (off_bad) begin
            res_status <= ffpa_pkg::STATUS_BAD_ADDR;
            state      <= ST_RESULT;
          end else begin
            p       <= off[ffpa_pkg::PAGE_SHIFT+PW-1:ffpa_pkg::PAGE_SHIFT];
            rd_addr <= off[ffpa_pkg::PAGE_SHIFT+PW-1:ffpa_pkg::PAGE_SHIFT];
            state   <= ST_F_WAIT;
          end
        end
        ST_F_WAIT: begin
          state <= ST_F_EVAL;
        end
        ST_F_EVAL: begin
          if (!rd_start) begin
            res_status <= ffpa_pkg::STATUS_BAD_ADDR;
            state      <= ST_RESULT;
          end else begin
            p       <= '0;
            rd_addr <= '0;
            state   <= ST_C_WAITP;
          end
        end
        ST_C_WAITP: begin
          state <= ST_C_EVALP;
        end
        ST_C_EVALP: begin
          sz     <= rd_count;
          p_free <= rd_free;
          if (rd_count == '0 || nxt_out) begin
            res_status <= ffpa_pkg::STATUS_OK;
            state      <= ST_RESULT;
          end else begin
            rd_addr <= PW'(nxt);
            state   <= ST_C_WAITQ;
          end
        end
        ST_C_WAITQ: begin
          state <= ST_C_EVALQ;
        end
        ST_C_EVALQ: begin
          if (p_free && rd_free) begin
            state <= ST_C_CLRQ;
          end else begin
            p     <= rd_addr;
            state <= ST_C_WAITP;
          end
        end
        ST_C_CLRQ: begin
          rd_addr <= p;
          state   <= ST_C_WAITP;
        end
        ST_RESULT: begin
          if (slot_free) begin
            rsp_valid        <= 1'b1;
            status           <= res_status;
            granted_virtual  <= res_grant ? virt_base + page_off : '0;
            granted_physical <= res_grant ? phys_base + page_off : '0;
            state            <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status != ffpa_pkg::STATUS_OK) |->
      (granted_virtual == '0) && (granted_physical == '0))
    else $error("failed result carries an address");

  assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> (state != ST_IDLE))
    else $error("accepted word started no work");

  assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (status != 2'd3))
    else $error("undefined status code");

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_A_TAKE) |-> ((take_cnt != '0) && (CMP_W'(take_cnt) >= need_c)))
    else $error("granted block smaller than request");

endmodule

`default_nettype wire

/* bench/ffpa_checker.sv */
// Checker for the first-fit page allocator: tracks the block table and bases,
// predicts the result word of every accepted request and compares it in order.
// Depends on ffpa_pkg.
`timescale 1ns / 1ps

module ffpa_checker #(
  parameter int POOL_PAGES = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  input  wire logic        req_stall,
  input  wire logic        op,
  input  wire logic [31:0] request_bytes,
  input  wire logic [63:0] release_address,
  input  wire logic        rsp_valid,
  input  wire logic        rsp_stall,
  input  wire logic [1:0]  status,
  input  wire logic [63:0] granted_virtual,
  input  wire logic [63:0] granted_physical,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [63:0] cfg_data,
  output int               failures,
  output int               outstanding
);

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] virt;
    logic [63:0] phys;
  } grant_t;

  grant_t          grants_due[$];
  bit              starts_block[POOL_PAGES];
  bit              block_free[POOL_PAGES];
  longint unsigned block_pages[POOL_PAGES];
  logic [63:0]     virt_base;
  logic [63:0]     phys_base;

  function automatic grant_t serve_request(input logic kind, input logic [31:0] bytes,
                                           input logic [63:0] addr);
    grant_t            g;
    longint unsigned   need;
    longint unsigned   at;
    longint unsigned   span;
    longint unsigned   nxt;
    logic [63:0]       off;
    g = '{status: ffpa_pkg::STATUS_OK, virt: '0, phys: '0};
    if (kind == ffpa_pkg::OP_ALLOC) begin
      g.status = ffpa_pkg::STATUS_NO_FIT;
      if (bytes == '0) return g;
      need = (64'(bytes) + ffpa_pkg::PAGE_BYTES - 1) / ffpa_pkg::PAGE_BYTES;
      at = 0;
      while (at < POOL_PAGES) begin
        span = block_pages[at];
        if (span == 0) break;
        if (starts_block[at] && block_free[at] && span >= need) begin
          if (span > need + 1) begin
            starts_block[at + need] = 1'b1;
            block_free[at + need]   = 1'b1;
            block_pages[at + need]  = span - need;
            block_pages[at]         = need;
          end
          block_free[at] = 1'b0;
          g.status = ffpa_pkg::STATUS_OK;
          g.virt   = virt_base + at * ffpa_pkg::PAGE_BYTES;
          g.phys   = phys_base + at * ffpa_pkg::PAGE_BYTES;
          return g;
        end
        at += span;
      end
      return g;
    end
    if (addr == '0) return g;
    off = addr - virt_base;
    if (off % ffpa_pkg::PAGE_BYTES != 0 || off / ffpa_pkg::PAGE_BYTES >= POOL_PAGES ||
        !starts_block[off / ffpa_pkg::PAGE_BYTES]) begin
      g.status = ffpa_pkg::STATUS_BAD_ADDR;
      return g;
    end
    block_free[off / ffpa_pkg::PAGE_BYTES] = 1'b1;
    // merge every run of adjacent free blocks
    at = 0;
    while (at < POOL_PAGES) begin
      span = block_pages[at];
      if (span == 0) break;
      nxt = at + span;
      if (nxt >= POOL_PAGES) break;
      if (block_free[at] && block_free[nxt]) begin
        block_pages[at]   = span + block_pages[nxt];
        starts_block[nxt] = 1'b0;
        block_free[nxt]   = 1'b0;
        block_pages[nxt]  = 0;
      end else begin
        at = nxt;
      end
    end
    return g;
  endfunction

  always @(posedge clk) begin
    grant_t due;
    if (rst) begin
      for (int p = 0; p < POOL_PAGES; p++) begin
        starts_block[p] = 1'b0;
        block_free[p]   = 1'b0;
        block_pages[p]  = 0;
      end
      starts_block[0] = 1'b1;
      block_free[0]   = 1'b1;
      block_pages[0]  = 64'(POOL_PAGES);
      virt_base = '0;
      phys_base = '0;
      grants_due.delete();
      failures = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == ffpa_pkg::CFG_VIRT_BASE) virt_base = cfg_data;
        else phys_base = cfg_data;
      end
      if (rsp_valid && !rsp_stall) begin
        if (grants_due.size() == 0) begin
          failures++;
          $error("result word with no request waiting: status %0d", status);
        end else begin
          due = grants_due.pop_front();
          if (status !== due.status) begin
            failures++;
            $error("status expected %0d actual %0d", due.status, status);
          end
          if (granted_virtual !== due.virt) begin
            failures++;
            $error("granted_virtual expected %h actual %h", due.virt, granted_virtual);
          end
          if (granted_physical !== due.phys) begin
            failures++;
            $error("granted_physical expected %h actual %h", due.phys, granted_physical);
          end
        end
      end
      if (req_valid && !req_stall)
        grants_due.push_back(serve_request(op, request_bytes, release_address));
    end
    outstanding = grants_due.size();
  end

endmodule

/* bench/tb_first_fit_page_allocator_core.sv */
// Testbench top for first_fit_page_allocator_core: clock, reset, directed and
// random request words, base register writes and the verdict.
// Depends on ffpa_pkg, the core and ffpa_checker.
`timescale 1ns / 1ps

module tb_first_fit_page_allocator_core;

  localparam int POOL_PAGES = 4096;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  logic        op = ffpa_pkg::OP_ALLOC;
  logic [31:0] request_bytes = '0;
  logic [63:0] release_address = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  logic [1:0]  status;
  logic [63:0] granted_virtual;
  logic [63:0] granted_physical;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = ffpa_pkg::CFG_VIRT_BASE;
  logic [63:0] cfg_data = '0;

  int          failures;
  int          outstanding;
  logic [63:0] virt_base = '0;
  int          live_pages[$];
  int          stall_left = 0;
  int          stall_mode = 0;

  first_fit_page_allocator_core #(.POOL_PAGES(POOL_PAGES)) dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall),
    .op(op), .request_bytes(request_bytes), .release_address(release_address),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
    .status(status), .granted_virtual(granted_virtual),
    .granted_physical(granted_physical),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  ffpa_checker #(.POOL_PAGES(POOL_PAGES)) chk (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall),
    .op(op), .request_bytes(request_bytes), .release_address(release_address),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
    .status(status), .granted_virtual(granted_virtual),
    .granted_physical(granted_physical),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .failures(failures), .outstanding(outstanding)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #(64'd60_000_000);
    $display("status: fail");
    $finish;
  end

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 200);
    end
    stall_left--;
    case (stall_mode)
      0: rsp_stall <= 1'b0;
      1: rsp_stall <= ($urandom_range(0, 3) == 0);
      2: rsp_stall <= ($urandom_range(0, 1) == 1);
      default: rsp_stall <= (stall_left % 16) < 12;
    endcase
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall && status == ffpa_pkg::STATUS_OK &&
        granted_virtual != '0)
      live_pages.push_back(int'((granted_virtual - virt_base) >> ffpa_pkg::PAGE_SHIFT));
  end

  function automatic logic [63:0] page_addr(input longint unsigned page);
    return virt_base + page * ffpa_pkg::PAGE_BYTES;
  endfunction

  task automatic send_word(input logic kind, input logic [31:0] bytes,
                           input logic [63:0] addr);
    req_valid <= 1'b1;
    op <= kind;
    request_bytes <= bytes;
    release_address <= addr;
    do @(posedge clk); while (req_stall);
    @(negedge clk);
  endtask

  task automatic hold_off(input int cycles);
    if (cycles > 0) begin
      req_valid <= 1'b0;
      repeat (cycles) @(negedge clk);
    end
  endtask

  task automatic drain();
    hold_off(1);
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic set_bases(input logic [63:0] vb, input logic [63:0] pb);
    cfg_valid <= 1'b1;
    cfg_index <= ffpa_pkg::CFG_VIRT_BASE;
    cfg_data <= vb;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_index <= ffpa_pkg::CFG_PHYS_BASE;
    cfg_data <= pb;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    virt_base = vb;
  endtask

  task automatic random_run(input int count);
    int          burst;
    int          idx;
    logic [31:0] bytes;
    logic [63:0] addr;
    burst = $urandom_range(1, 24);
    for (int i = 0; i < count; i++) begin
      bytes = $urandom;
      addr  = {$urandom, $urandom};
      idx   = $urandom_range(0, 99);
      if (idx < 55) begin
        case ($urandom_range(0, 19))
          0:       bytes = '0;
          1:       bytes = $urandom;
          2, 3:    bytes = $urandom_range(1, 64) * ffpa_pkg::PAGE_BYTES;
          4:       bytes = $urandom_range(1, 64) * ffpa_pkg::PAGE_BYTES + 1;
          default: bytes = $urandom_range(1, 8 * ffpa_pkg::PAGE_BYTES);
        endcase
        send_word(ffpa_pkg::OP_ALLOC, bytes, addr);
      end else if (idx < 88 && live_pages.size() > 0) begin
        idx  = $urandom_range(0, live_pages.size() - 1);
        addr = page_addr(live_pages[idx]);
        // keep a few entries to provoke double frees
        if ($urandom_range(0, 9) != 0) live_pages.delete(idx);
        send_word(ffpa_pkg::OP_FREE, bytes, addr);
      end else begin
        case ($urandom_range(0, 4))
          0: addr = '0;
          1: addr = {$urandom, $urandom};
          2: addr = page_addr($urandom_range(0, POOL_PAGES - 1)) +
                    $urandom_range(1, ffpa_pkg::PAGE_BYTES - 1);
          3: addr = page_addr(POOL_PAGES + $urandom_range(0, 1 << 20));
          default: addr = page_addr($urandom_range(0, POOL_PAGES - 1));
        endcase
        send_word(ffpa_pkg::OP_FREE, bytes, addr);
      end
      burst--;
      if (burst == 0) begin
        hold_off($urandom_range(1, 12));
        burst = $urandom_range(1, 24);
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    set_bases('0, '0);

    send_word(ffpa_pkg::OP_ALLOC, '0, {$urandom, $urandom});
    send_word(ffpa_pkg::OP_ALLOC, 32'd1, {$urandom, $urandom});
    send_word(ffpa_pkg::OP_ALLOC, ffpa_pkg::PAGE_BYTES, {$urandom, $urandom});
    send_word(ffpa_pkg::OP_ALLOC, ffpa_pkg::PAGE_BYTES + 1, {$urandom, $urandom});
    send_word(ffpa_pkg::OP_ALLOC, 32'hFFFF_FFFF, {$urandom, $urandom});
    send_word(ffpa_pkg::OP_ALLOC, (POOL_PAGES - 5) * ffpa_pkg::PAGE_BYTES,
              {$urandom, $urandom});
    send_word(ffpa_pkg::OP_ALLOC, 32'd1, {$urandom, $urandom});
    send_word(ffpa_pkg::OP_FREE, $urandom, '0);
    send_word(ffpa_pkg::OP_FREE, $urandom, page_addr(4));
    send_word(ffpa_pkg::OP_FREE, $urandom, page_addr(4) + 1);
    send_word(ffpa_pkg::OP_FREE, $urandom, page_addr(POOL_PAGES));
    send_word(ffpa_pkg::OP_FREE, $urandom, page_addr(5));
    send_word(ffpa_pkg::OP_FREE, $urandom, page_addr(4));
    send_word(ffpa_pkg::OP_FREE, $urandom, page_addr(1));
    send_word(ffpa_pkg::OP_FREE, $urandom, page_addr(2));
    send_word(ffpa_pkg::OP_ALLOC, (POOL_PAGES - 1) * ffpa_pkg::PAGE_BYTES,
              {$urandom, $urandom});
    send_word(ffpa_pkg::OP_FREE, $urandom, page_addr(0));
    send_word(ffpa_pkg::OP_FREE, $urandom, 64'hFFFF_FFFF_FFFF_FFFF);
    send_word(ffpa_pkg::OP_FREE, $urandom, page_addr(1));
    send_word(ffpa_pkg::OP_ALLOC, 2 * ffpa_pkg::PAGE_BYTES + 1, {$urandom, $urandom});
    drain();
    live_pages = '{1};
    random_run(45);

    drain();
    set_bases(64'hFFFF_FFFF_FFFF_F000, 64'h0000_0000_8000_0000);
    send_word(ffpa_pkg::OP_FREE, $urandom, page_addr(0));
    send_word(ffpa_pkg::OP_ALLOC, 32'd1, {$urandom, $urandom});
    random_run(20);
    drain();
    random_run(25);

    drain();
    set_bases({$urandom, $urandom}, {$urandom, $urandom});
    random_run(18);

    drain();
    set_bases('1, '1);
    random_run(10);

    drain();
    repeat (3 * POOL_PAGES) @(negedge clk);
    if (failures == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* first_fit_page_allocator_core.f */
src/ffpa_pkg.sv
src/first_fit_page_allocator_core.sv
bench/ffpa_checker.sv
bench/tb_first_fit_page_allocator_core.sv
